// File: rtl/core/prq_pkg.sv
package prq_pkg;

	// Operation codes of an input item
	typedef enum logic [1:0] {
		OP_PUSH     = 2'd0,
		OP_RD_FRONT = 2'd1,
		OP_RD_BACK  = 2'd2,
		OP_REMOVE   = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_FULL  = 3'd2,
		ST_LONG  = 3'd3,
		ST_RANGE = 3'd4
	} status_t;

	localparam int OFFSET_W = 11;
	localparam int LENGTH_W = 12;
	localparam int BYTE_W   = 8;

endpackage

// File: rtl/core/packet_ring_queue_core.sv
// One result per accepted item, with done high in the cycle after the accept edge.
// Throughput: one item per cycle; busy stays low, since every item needs one read of the
// payload and length memories and those reads never collide with the writes of the same edge.
// Reset (arst_n low, asynchronous): queue empty, head and tail at slot 0, no packet in flight.
// Memory contents are not cleared; only committed slots are ever read.
// The receiver cannot stall: each result is shown for exactly one cycle.
module packet_ring_queue_core #(
	parameter int SLOTS     = 16,
	parameter int MAX_BYTES = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  prq_pkg::op_t                    op,
	input  logic [prq_pkg::BYTE_W-1:0]      data_in,
	input  logic                            last,
	input  logic [prq_pkg::OFFSET_W-1:0]    offset,
	output logic                            done,
	output logic [prq_pkg::BYTE_W-1:0]      data_out,
	output logic [prq_pkg::LENGTH_W-1:0]    length,
	output prq_pkg::status_t                status,
	output logic                            is_empty_now,
	output logic                            is_full_now
);
	import prq_pkg::*;

	// Slot index, occupancy count, byte position, packet length widths
	localparam int SW    = $clog2(SLOTS);
	localparam int CNTW  = $clog2(SLOTS + 1);
	localparam int PW    = $clog2(MAX_BYTES);
	localparam int LW    = $clog2(MAX_BYTES + 1);
	localparam int CW    = (LW > OFFSET_W) ? LW : OFFSET_W;
	localparam int DEPTH = SLOTS * (2 ** PW);

	// How the output stage builds the result of an item
	typedef enum logic [1:0] {
		K_DIRECT,   // push results and empty status: fully known at accept
		K_READ,     // byte and length come from the memories
		K_REMOVE    // length comes from the length memory
	} kind_t;

	// Occupied slots always form the run head..tail-1 (wrapping), so a count
	// replaces per-slot valid bits: a slot is free iff it lies outside that run.
	logic [SW-1:0]   head_q, tail_q;
	logic [CNTW-1:0] cnt_q;
	logic [LW-1:0]   wc_q;     // bytes of the packet being pushed
	logic            drop_q;   // discarding the rest of a dropped packet

	logic [SW-1:0]   head_d, tail_d;
	logic [CNTW-1:0] cnt_d;
	logic [LW-1:0]   wc_d;
	logic            drop_d;
	logic [LW-1:0]   wc_inc;

	// Memories: payload bytes at {slot, position}, committed length per slot
	logic [BYTE_W-1:0] pay_mem [DEPTH];
	logic [LW-1:0]     len_mem [SLOTS];

	logic              pay_we, len_we;
	logic [SW-1:0]     rd_slot;
	logic [PW-1:0]     rd_pos;

	// Stage 1: item decoded, memory read data returning
	logic              valid_s1;
	kind_t             kind_s1, kind_d;
	status_t           status_s1, status_d;
	logic [LW-1:0]     len_s1, len_d;
	logic [OFFSET_W-1:0] offset_s1;
	logic              empty_s1, full_s1;
	logic [BYTE_W-1:0] pay_rd_s1;
	logic [LW-1:0]     len_rd_s1;

	function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] i);
		return (i == SW'(SLOTS - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [SW-1:0] slot_prev(input logic [SW-1:0] i);
		return (i == '0) ? SW'(SLOTS - 1) : i - 1'b1;
	endfunction

	assign busy   = 1'b0;
	assign wc_inc = wc_q + 1'b1;
	// Out-of-range offsets may alias here; the length compare rejects them later.
	assign rd_pos = PW'(offset);

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		cnt_d    = cnt_q;
		wc_d     = wc_q;
		drop_d   = drop_q;
		pay_we   = 1'b0;
		len_we   = 1'b0;
		rd_slot  = head_q;
		kind_d   = K_DIRECT;
		status_d = ST_OK;
		len_d    = '0;
		if (start) begin
			case (op)
				OP_PUSH: begin
					if (drop_q) begin
						// tail of a dropped packet: swallow quietly
						if (last) drop_d = 1'b0;
					end else if (wc_q == '0 && cnt_q == CNTW'(SLOTS)) begin
						status_d = ST_FULL;
						drop_d   = !last;
					end else if (wc_q == LW'(MAX_BYTES)) begin
						status_d = ST_LONG;
						wc_d     = '0;
						drop_d   = !last;
					end else begin
						pay_we = 1'b1;
						len_d  = wc_inc;
						wc_d   = wc_inc;
						if (last) begin
							// commit: length into the rear slot, rear advances
							len_we = 1'b1;
							tail_d = slot_next(tail_q);
							cnt_d  = cnt_q + 1'b1;
							wc_d   = '0;
						end
					end
				end
				OP_REMOVE: begin
					if (cnt_q == '0) begin
						status_d = ST_EMPTY;
					end else begin
						kind_d = K_REMOVE;
						head_d = slot_next(head_q);
						cnt_d  = cnt_q - 1'b1;
					end
				end
				OP_RD_FRONT, OP_RD_BACK: begin
					if (cnt_q == '0) begin
						status_d = ST_EMPTY;
					end else begin
						kind_d  = K_READ;
						rd_slot = (op == OP_RD_FRONT) ? head_q : slot_prev(tail_q);
					end
				end
				default: ;
			endcase
		end
	end

	// Memory writes and registered reads. A write only touches the rear slot,
	// which is free, and reads only reach occupied slots: no same-entry overlap.
	always_ff @(posedge clk) begin
		if (pay_we) pay_mem[{tail_q, wc_q[PW-1:0]}] <= data_in;
		if (len_we) len_mem[tail_q] <= wc_inc;
		pay_rd_s1 <= pay_mem[{rd_slot, rd_pos}];
		len_rd_s1 <= len_mem[rd_slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			cnt_q    <= '0;
			wc_q     <= '0;
			drop_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			head_q   <= head_d;
			tail_q   <= tail_d;
			cnt_q    <= cnt_d;
			wc_q     <= wc_d;
			drop_q   <= drop_d;
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			kind_s1   <= kind_d;
			status_s1 <= status_d;
			len_s1    <= len_d;
			offset_s1 <= offset;
			empty_s1  <= (cnt_d == '0);
			full_s1   <= (cnt_d == CNTW'(SLOTS));
		end
	end

	// Result assembly from stage 1 and the memory read data
	always_comb begin
		data_out = '0;
		length   = LENGTH_W'(len_s1);
		status   = status_s1;
		case (kind_s1)
			K_READ: begin
				length = LENGTH_W'(len_rd_s1);
				if (CW'(offset_s1) >= CW'(len_rd_s1)) status = ST_RANGE;
				else data_out = pay_rd_s1;
			end
			K_REMOVE: length = LENGTH_W'(len_rd_s1);
			default: ;
		endcase
	end

	assign done         = valid_s1;
	assign is_empty_now = empty_s1;
	assign is_full_now  = full_s1;

endmodule

// File: rtl/core/prq_checker.sv
module prq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [prq_pkg::BYTE_W-1:0]   data_out,
	input logic [prq_pkg::LENGTH_W-1:0] length,
	input prq_pkg::status_t             status,
	input logic                         is_empty_now,
	input logic                         is_full_now
);
	import prq_pkg::*;

	// every accepted item yields its result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted item without result");

	// no result without an accepted item
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without accepted item");

	a_empty_full: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(is_empty_now && is_full_now))
		else $error("queue both empty and full");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (length == '0 && data_out == '0 && is_empty_now))
		else $error("empty status with data");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_RANGE || status == ST_FULL || status == ST_LONG))
			|-> data_out == '0)
		else $error("data on failing status");

endmodule

bind packet_ring_queue_core prq_checker u_prq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.data_out     (data_out),
	.length       (length),
	.status       (status),
	.is_empty_now (is_empty_now),
	.is_full_now  (is_full_now)
);
